// ----- design/lqkr_pkg.sv -----
package lqkr_pkg;

    localparam int OP_W       = 3;
    localparam int TAG_W      = 16;
    localparam int DEF_DEPTH  = 16;
    localparam int DEF_QUEUES = 2;
    localparam int DEF_TAG_BITS = 16;

    typedef enum logic [OP_W-1:0] {
        OP_PUT    = 3'd0,
        OP_GET    = 3'd1,
        OP_REMOVE = 3'd2,
        OP_MOVE   = 3'd3,
        OP_ITER   = 3'd4
    } t_op;

endpackage

// ----- design/lqkr_if.sv -----
interface lqkr_req_if;
    import lqkr_pkg::*;

    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  op;
    logic             queue;
    logic             dest_queue;
    logic [TAG_W-1:0] tag;
    logic             restart;

    modport source (output valid, op, queue, dest_queue, tag, restart, input ready);
    modport sink   (input valid, op, queue, dest_queue, tag, restart, output ready);
endinterface

interface lqkr_rsp_if;
    import lqkr_pkg::*;

    logic             valid;
    logic             ready;
    logic             status;
    logic             found;
    logic [TAG_W-1:0] out_tag;

    modport source (output valid, status, found, out_tag, input ready);
    modport sink   (input valid, status, found, out_tag, output ready);
endinterface

// ----- design/lqkr_ram.sv -----
module lqkr_ram #(
    parameter int AW = 4,
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- design/linked_queue_with_keyed_remove_top.sv -----
// Linked queues with keyed remove: QUEUES FIFO queues of nonzero tags kept as
// doubly linked lists in one pool of DEPTH entries. Ops: put (append), get
// (pop head, returns tag), remove (find tag from head, unlink), move (unlink
// from queue, append to dest_queue) and iterate (head on restart or with no
// cursor, else entry after a per-queue cursor). One item is worked at a time
// and returns exactly one result item. Entry tag, next and prev links live in
// three one-read, one-write memories with a registered read. Remove and move
// walk the list from the head; a miss walks the whole list. Free entries come
// first from a free stack threaded through the next links, then from a fill
// counter, so no clearing pass is needed after reset.
module linked_queue_with_keyed_remove_top #(
    parameter int DEPTH    = lqkr_pkg::DEF_DEPTH,
    parameter int QUEUES   = lqkr_pkg::DEF_QUEUES,
    parameter int TAG_BITS = lqkr_pkg::DEF_TAG_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    lqkr_req_if.sink   i_req,
    lqkr_rsp_if.source o_rsp
);
    import lqkr_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int PW = $clog2(DEPTH + 1);
    localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam int TW = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
    localparam logic [PW-1:0] NIL = PW'(DEPTH);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_DEC   = 10'b0000000010,
        S_PFREE = 10'b0000000100,
        S_WALK  = 10'b0000001000,
        S_INXT  = 10'b0000010000,
        S_ITAG  = 10'b0000100000,
        S_FREE  = 10'b0001000000,
        S_LINKA = 10'b0010000000,
        S_LINKB = 10'b0100000000,
        S_FIN   = 10'b1000000000
    } t_state;

    t_state r_state;

    // latched item
    logic [OP_W-1:0] r_op;
    logic            r_q;
    logic            r_d;
    logic [TW-1:0]   r_tag;
    logic            r_restart;

    // working pointers and result
    logic [PW-1:0] r_e;
    logic [PW-1:0] r_t;
    logic          r_fail;
    logic          r_found;
    logic [TW-1:0] r_otag;

    // per-queue state and pool bookkeeping
    logic [PW-1:0] r_head [QUEUES];
    logic [PW-1:0] r_tail [QUEUES];
    logic [PW-1:0] r_cur  [QUEUES];
    logic [PW-1:0] r_free_head;
    logic [PW-1:0] r_fill;

    // result register
    logic             r_ovalid;
    logic             r_ostatus;
    logic             r_ofound;
    logic [TAG_W-1:0] r_ootag;

    // memory ports
    logic [IW-1:0] raddr;
    logic          tag_we,  nxt_we,  prv_we;
    logic [IW-1:0] tag_wa,  nxt_wa,  prv_wa;
    logic [TW-1:0] tag_wd;
    logic [PW-1:0] nxt_wd,  prv_wd;
    logic [TW-1:0] rtag;
    logic [PW-1:0] rnext,   rprev;

    logic [QW-1:0] qi, di, lqi;
    logic          q_ok, d_ok, match, is_op;
    logic [PW-1:0] head_q, cur_q, tail_l;

    assign qi     = QW'(r_q);
    assign di     = QW'(r_d);
    assign lqi    = (r_op == OP_MOVE) ? di : qi;
    assign q_ok   = (int'(r_q) < QUEUES);
    assign d_ok   = (int'(r_d) < QUEUES);
    assign head_q = r_head[qi];
    assign cur_q  = r_cur[qi];
    assign tail_l = r_tail[lqi];
    assign match  = (r_op == OP_GET) || (rtag == r_tag);
    assign is_op  = (r_op == OP_PUT) || (r_op == OP_GET) || (r_op == OP_REMOVE)
                 || (r_op == OP_MOVE) || (r_op == OP_ITER);

    lqkr_ram #(.AW(IW), .DW(TW)) u_tag (
        .i_clk(i_clk), .i_we(tag_we), .i_waddr(tag_wa), .i_wdata(tag_wd),
        .i_raddr(raddr), .o_rdata(rtag)
    );
    lqkr_ram #(.AW(IW), .DW(PW)) u_next (
        .i_clk(i_clk), .i_we(nxt_we), .i_waddr(nxt_wa), .i_wdata(nxt_wd),
        .i_raddr(raddr), .o_rdata(rnext)
    );
    lqkr_ram #(.AW(IW), .DW(PW)) u_prev (
        .i_clk(i_clk), .i_we(prv_we), .i_waddr(prv_wa), .i_wdata(prv_wd),
        .i_raddr(raddr), .o_rdata(rprev)
    );

    // Memory address and write control per state.
    always_comb begin
        raddr  = '0;
        tag_we = 1'b0;  tag_wa = r_e[IW-1:0]; tag_wd = r_tag;
        nxt_we = 1'b0;  nxt_wa = r_e[IW-1:0]; nxt_wd = NIL;
        prv_we = 1'b0;  prv_wa = r_e[IW-1:0]; prv_wd = NIL;
        unique case (r_state)
            S_DEC: begin
                if (r_op == OP_PUT) begin
                    raddr = r_free_head[IW-1:0];
                end else if (r_op == OP_ITER && !r_restart && cur_q != NIL) begin
                    raddr = cur_q[IW-1:0];
                end else begin
                    raddr = head_q[IW-1:0];
                end
            end
            S_WALK, S_INXT: begin
                raddr = rnext[IW-1:0];
                if (r_state == S_WALK && match) begin
                    // unlink: bridge predecessor and successor
                    nxt_we = (rprev != NIL);
                    nxt_wa = rprev[IW-1:0];
                    nxt_wd = rnext;
                    prv_we = (rnext != NIL);
                    prv_wa = rnext[IW-1:0];
                    prv_wd = rprev;
                end
            end
            S_FREE: begin
                nxt_we = 1'b1;
                nxt_wd = r_free_head;
            end
            S_LINKA: begin
                tag_we = 1'b1;
                nxt_we = 1'b1;
                prv_we = 1'b1;
                prv_wd = tail_l;
            end
            S_LINKB: begin
                nxt_we = 1'b1;
                nxt_wa = r_t[IW-1:0];
                nxt_wd = r_e;
            end
            default: begin
            end
        endcase
    end

    assign i_req.ready    = (r_state == S_IDLE);
    assign o_rsp.valid    = r_ovalid;
    assign o_rsp.status   = r_ostatus;
    assign o_rsp.found    = r_ofound;
    assign o_rsp.out_tag  = r_ootag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free_head <= NIL;
            r_fill      <= '0;
            r_ovalid    <= 1'b0;
            for (int k = 0; k < QUEUES; k++) begin
                r_head[k] <= NIL;
                r_tail[k] <= NIL;
                r_cur[k]  <= NIL;
            end
        end else begin
            // drop the result once taken, unless a new one replaces it now
            if (r_ovalid && o_rsp.ready && r_state != S_FIN) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_op      <= i_req.op;
                        r_q       <= i_req.queue;
                        r_d       <= i_req.dest_queue;
                        r_tag     <= i_req.tag[TW-1:0];
                        r_restart <= i_req.restart;
                        r_state   <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_fail  <= 1'b1;
                    r_found <= 1'b0;
                    r_otag  <= '0;
                    r_state <= S_FIN;
                    if (q_ok && is_op) begin
                        priority case (r_op)
                            OP_PUT: begin
                                if (r_tag != '0) begin
                                    if (r_free_head != NIL) begin
                                        r_e     <= r_free_head;
                                        r_state <= S_PFREE;
                                    end else if (r_fill != NIL) begin
                                        r_e     <= r_fill;
                                        r_fill  <= r_fill + 1'b1;
                                        r_state <= S_LINKA;
                                    end
                                end
                            end
                            OP_GET: begin
                                if (head_q != NIL) begin
                                    r_e     <= head_q;
                                    r_state <= S_WALK;
                                end
                            end
                            OP_REMOVE, OP_MOVE: begin
                                if (r_tag != '0 && head_q != NIL
                                    && (r_op == OP_REMOVE || d_ok)) begin
                                    r_e     <= head_q;
                                    r_state <= S_WALK;
                                end
                            end
                            default: begin
                                // iterate
                                if (!r_restart && cur_q != NIL) begin
                                    r_state <= S_INXT;
                                end else if (head_q != NIL) begin
                                    r_e     <= head_q;
                                    r_state <= S_ITAG;
                                end
                            end
                        endcase
                    end
                end
                S_PFREE: begin
                    // pop the free stack
                    r_free_head <= rnext;
                    r_state     <= S_LINKA;
                end
                S_WALK: begin
                    if (match) begin
                        if (rprev == NIL) begin
                            r_head[qi] <= rnext;
                        end
                        if (rnext == NIL) begin
                            r_tail[qi] <= rprev;
                        end
                        for (int k = 0; k < QUEUES; k++) begin
                            if (r_cur[k] == r_e) begin
                                r_cur[k] <= rprev;
                            end
                        end
                        if (r_op == OP_GET) begin
                            r_found <= 1'b1;
                            r_otag  <= rtag;
                        end
                        r_state <= (r_op == OP_MOVE) ? S_LINKA : S_FREE;
                    end else if (rnext == NIL) begin
                        r_state <= S_FIN;
                    end else begin
                        r_e <= rnext;
                    end
                end
                S_INXT: begin
                    if (rnext == NIL) begin
                        r_state <= S_FIN;
                    end else begin
                        r_e     <= rnext;
                        r_state <= S_ITAG;
                    end
                end
                S_ITAG: begin
                    r_cur[qi] <= r_e;
                    r_otag    <= rtag;
                    r_found   <= 1'b1;
                    r_fail    <= 1'b0;
                    r_state   <= S_FIN;
                end
                S_FREE: begin
                    // push onto the free stack
                    r_free_head <= r_e;
                    r_fail      <= 1'b0;
                    r_state     <= S_FIN;
                end
                S_LINKA: begin
                    r_t         <= tail_l;
                    r_tail[lqi] <= r_e;
                    if (tail_l == NIL) begin
                        r_head[lqi] <= r_e;
                        r_fail      <= 1'b0;
                        r_state     <= S_FIN;
                    end else begin
                        r_state <= S_LINKB;
                    end
                end
                S_LINKB: begin
                    r_fail  <= 1'b0;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    // hold until the result register is free
                    if (!r_ovalid || o_rsp.ready) begin
                        r_ovalid  <= 1'b1;
                        r_ostatus <= r_fail;
                        r_ofound  <= r_found;
                        r_ootag   <= TAG_W'(r_otag);
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule

// ----- tb/sv/linked_queue_with_keyed_remove_top_tb.sv -----
module linked_queue_with_keyed_remove_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lqkr_pkg::*;

    localparam int DEPTH     = DEF_DEPTH;
    localparam int QUEUES    = DEF_QUEUES;
    localparam int NIL       = DEPTH;
    localparam int IDLE_WAIT = 2 * DEPTH + 20;
    localparam int WDOG_MAX  = 4000;
    localparam int N_RANDOM  = 370;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic             queue;
        logic             dest_queue;
        logic [TAG_W-1:0] tag;
        logic             restart;
    } t_cmd;

    typedef struct packed {
        logic             status;
        logic             found;
        logic [TAG_W-1:0] out_tag;
    } t_reply;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    lqkr_req_if req_bus ();
    lqkr_rsp_if rsp_bus ();

    linked_queue_with_keyed_remove_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus.sink),
        .o_rsp   (rsp_bus.source)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Shadow of the list pool: tags, links, heads, tails, cursors, free map.
    logic [TAG_W-1:0] pool_tag  [DEPTH];
    int               pool_next [DEPTH];
    int               pool_prev [DEPTH];
    bit               pool_free [DEPTH];
    int               list_head [QUEUES];
    int               list_tail [QUEUES];
    int               walk_pos  [QUEUES];

    t_cmd   cmd_pending[$];
    t_reply reply_due[$];
    int     error_count = 0;
    int     idle_cycles = 0;

    task automatic report_mismatch(input string what);
        $display("mismatch @%0t: %s", $realtime, what);
        error_count++;
    endtask

    function automatic void shadow_reset();
        for (int i = 0; i < DEPTH; i++) begin
            pool_free[i] = 1'b1;
            pool_tag[i] = '0;
            pool_next[i] = 0;
            pool_prev[i] = 0;
        end
        for (int k = 0; k < QUEUES; k++) begin
            list_head[k] = NIL;
            list_tail[k] = NIL;
            walk_pos[k] = NIL;
        end
    endfunction

    function automatic void append_entry(int q, int e);
        int t;
        t = list_tail[q];
        pool_next[e] = NIL;
        pool_prev[e] = t;
        if (t < NIL) pool_next[t] = e;
        else list_head[q] = e;
        list_tail[q] = e;
    endfunction

    // Unlink an entry; pull any cursor sitting on it back to its predecessor.
    function automatic void detach_entry(int q, int e);
        int n, p;
        n = pool_next[e];
        p = pool_prev[e];
        if (p < NIL) pool_next[p] = n;
        else list_head[q] = n;
        if (n < NIL) pool_prev[n] = p;
        else list_tail[q] = p;
        for (int k = 0; k < QUEUES; k++)
            if (walk_pos[k] == e) walk_pos[k] = p;
    endfunction

    function automatic int search_tag(int q, logic [TAG_W-1:0] tag);
        int e, steps;
        e = list_head[q];
        steps = 0;
        while (e < NIL && steps < DEPTH) begin
            if (pool_tag[e] == tag) return e;
            e = pool_next[e];
            steps++;
        end
        return NIL;
    endfunction

    function automatic t_reply apply_queue_op(t_cmd c);
        t_reply r;
        int q, e;
        r = '{status: 1'b1, found: 1'b0, out_tag: '0};
        q = int'(c.queue);
        e = NIL;
        case (c.op)
            OP_PUT: if (c.tag != 0) begin
                for (int i = 0; i < DEPTH; i++)
                    if (pool_free[i] && e == NIL) e = i;
                if (e < NIL) begin
                    pool_free[e] = 1'b0;
                    pool_tag[e] = c.tag;
                    append_entry(q, e);
                    r.status = 1'b0;
                end
            end
            OP_GET: begin
                e = list_head[q];
                if (e < NIL) begin
                    r.out_tag = pool_tag[e];
                    detach_entry(q, e);
                    pool_free[e] = 1'b1;
                    r.status = 1'b0;
                    r.found = 1'b1;
                end
            end
            OP_REMOVE: if (c.tag != 0) begin
                e = search_tag(q, c.tag);
                if (e < NIL) begin
                    detach_entry(q, e);
                    pool_free[e] = 1'b1;
                    r.status = 1'b0;
                end
            end
            OP_MOVE: if (c.tag != 0) begin
                e = search_tag(q, c.tag);
                if (e < NIL) begin
                    detach_entry(q, e);
                    append_entry(int'(c.dest_queue), e);
                    r.status = 1'b0;
                end
            end
            OP_ITER: begin
                e = walk_pos[q];
                if (c.restart || e >= NIL) e = list_head[q];
                else e = pool_next[e];
                if (e < NIL) begin
                    walk_pos[q] = e;
                    r.out_tag = pool_tag[e];
                    r.status = 1'b0;
                    r.found = 1'b1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Driver: bursts of random length separated by random gaps.
    int   burst_left = 0;
    int   gap_left = 0;
    t_cmd cmd_now;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_bus.valid <= 1'b0;
        end else begin
            // Retire an item accepted at this edge before picking the next.
            if (req_bus.valid && req_bus.ready) begin
                cmd_now = cmd_pending.pop_front();
                reply_due.push_back(apply_queue_op(cmd_now));
            end
            if (req_bus.valid && !req_bus.ready) begin
                // hold the item until it is taken
            end else if (gap_left > 0) begin
                gap_left--;
                req_bus.valid <= 1'b0;
            end else if (cmd_pending.size() > 0) begin
                cmd_now = cmd_pending[0];
                req_bus.valid      <= 1'b1;
                req_bus.op         <= cmd_now.op;
                req_bus.queue      <= cmd_now.queue;
                req_bus.dest_queue <= cmd_now.dest_queue;
                req_bus.tag        <= cmd_now.tag;
                req_bus.restart    <= cmd_now.restart;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 7);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
                end
            end else begin
                req_bus.valid <= 1'b0;
            end
        end
    end

    // Monitor: receiver stalls on its own pattern; compare each reply.
    int     stall_phase = 0;
    t_reply got, want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
        end else begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                got = '{status: rsp_bus.status, found: rsp_bus.found,
                        out_tag: rsp_bus.out_tag};
                if (reply_due.size() == 0) begin
                    report_mismatch("reply with nothing outstanding");
                end else begin
                    want = reply_due.pop_front();
                    if (got.status !== want.status)
                        report_mismatch($sformatf("status %0b want %0b",
                                                  got.status, want.status));
                    if (got.found !== want.found)
                        report_mismatch($sformatf("found %0b want %0b",
                                                  got.found, want.found));
                    if (got.out_tag !== want.out_tag)
                        report_mismatch($sformatf("out_tag %h want %h",
                                                  got.out_tag, want.out_tag));
                end
            end
            // Phase-based stall: long open stretches, then choppy ones.
            stall_phase = (stall_phase + 1) % 64;
            rsp_bus.ready <= (stall_phase < 24) ? 1'b1 : ($urandom_range(0, 2) != 0);
        end
    end

    // Watchdog: count cycles without any handshake.
    always @(posedge i_clk) begin
        if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic t_cmd make_cmd(t_op op, int q, int dq, int tag, bit rs);
        t_cmd c;
        c.op = op;
        c.queue = q[0];
        c.dest_queue = dq[0];
        c.tag = tag[TAG_W-1:0];
        c.restart = rs;
        return c;
    endfunction

    // Tags live in a small pool so removes and moves hit often.
    logic [TAG_W-1:0] tag_pool[8];

    function automatic logic [TAG_W-1:0] pick_tag();
        int k;
        k = $urandom_range(0, 19);
        if (k < 16) return tag_pool[k % 8];
        if (k == 16) return '0;
        return TAG_W'($urandom_range(0, 16'hFFFF));
    endfunction

    initial begin
        t_cmd c;
        int   k;
        req_bus.valid = 1'b0;
        req_bus.op = '0;
        req_bus.queue = 1'b0;
        req_bus.dest_queue = 1'b0;
        req_bus.tag = '0;
        req_bus.restart = 1'b0;
        rsp_bus.ready = 1'b0;
        shadow_reset();
        for (int i = 0; i < 8; i++) tag_pool[i] = TAG_W'($urandom_range(1, 16'hFFFF));
        tag_pool[0] = 16'hFFFF;
        tag_pool[1] = 16'h0001;
        tag_pool[2] = 16'h5555;
        tag_pool[3] = 16'hAAAA;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty queues, zero tag, fill pool, full put, cursor cases.
        cmd_pending.push_back(make_cmd(OP_GET, 0, 0, 0, 0));
        cmd_pending.push_back(make_cmd(OP_ITER, 1, 0, 0, 0));
        cmd_pending.push_back(make_cmd(OP_PUT, 0, 0, 0, 0));
        cmd_pending.push_back(make_cmd(OP_REMOVE, 0, 0, 0, 0));
        cmd_pending.push_back(make_cmd(OP_MOVE, 0, 1, 0, 0));
        for (int i = 0; i < DEPTH; i++)
            cmd_pending.push_back(make_cmd(OP_PUT, i % 2, 0, tag_pool[i % 4] + i, 0));
        cmd_pending.push_back(make_cmd(OP_PUT, 1, 0, 16'hFFFF, 0));
        cmd_pending.push_back(make_cmd(OP_ITER, 0, 0, 0, 1));
        cmd_pending.push_back(make_cmd(OP_REMOVE, 0, 0, tag_pool[0], 0));
        cmd_pending.push_back(make_cmd(OP_ITER, 0, 0, 0, 0));
        cmd_pending.push_back(make_cmd(OP_MOVE, 1, 1, tag_pool[1] + 1, 0));
        cmd_pending.push_back(make_cmd(OP_MOVE, 1, 0, tag_pool[3] + 3, 0));
        cmd_pending.push_back(make_cmd(OP_REMOVE, 1, 0, 16'h1234, 1));
        cmd_pending.push_back(make_cmd(t_op'(3'd7), 1, 1, 16'hFFFF, 1));

        // Random: mostly valid ops on a small tag set; odd codes now and then.
        for (int n = 0; n < N_RANDOM; n++) begin
            k = $urandom_range(0, 99);
            c.queue = 1'($urandom_range(0, 1));
            c.dest_queue = 1'($urandom_range(0, 1));
            c.restart = $urandom_range(0, 3) == 0;
            c.tag = pick_tag();
            if (k < 32) c.op = OP_PUT;
            else if (k < 46) c.op = OP_GET;
            else if (k < 60) c.op = OP_REMOVE;
            else if (k < 76) c.op = OP_MOVE;
            else if (k < 97) c.op = OP_ITER;
            else c.op = OP_W'($urandom_range(5, 7));
            cmd_pending.push_back(c);
        end

        wait (cmd_pending.size() == 0);
        wait (reply_due.size() == 0);
        repeat (IDLE_WAIT) @(posedge i_clk);
        if (error_count == 0 && reply_due.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

// ----- filelist.f -----
design/lqkr_pkg.sv
design/lqkr_if.sv
design/lqkr_ram.sv
design/linked_queue_with_keyed_remove_top.sv
tb/sv/linked_queue_with_keyed_remove_top_tb.sv
